// ===== rtl/core/bbd_pkg.sv =====
`default_nettype none
package bbd_pkg;

  // Bytes that the decoder recognizes
  localparam logic [7:0] MsLead     = 8'hE2;
  localparam logic [7:0] MsMid      = 8'h96;
  localparam logic [7:0] MsLast     = 8'h81;
  localparam logic [7:0] SpaceByte  = 8'h20;
  localparam logic [7:0] LeadMask   = 8'hE0;
  localparam logic [7:0] LeadCode   = 8'hC0;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContCode   = 8'h80;
  localparam logic [7:0] DelByte    = 8'h7F;
  localparam logic [7:0] ShyByte    = 8'hAD;

  // Held-byte counter values
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldOne  = 2'd1;
  localparam logic [1:0] HeldTwo  = 2'd2;

  // One decoded item: up to three result bytes
  typedef struct packed {
    logic [1:0]      cnt;      // number of results, 0..3; 0 is not stored
    logic [2:0][7:0] data;     // result bytes, slot 0 first
    logic            data_vld; // 0 only for an empty closing result
    logic            done;     // last result closes the token
  } cmd_t;

  // Map a two-byte code point back to its raw byte; bit 8 says "keep"
  function automatic logic [8:0] cp_map(input logic [10:0] cp);
    logic [6:0] idx;
    logic [8:0] res;
    idx = cp[6:0];
    if (cp[10:8] == 3'd0) begin
      res = {1'b1, cp[7:0]};
    end else if (cp > 11'h143) begin
      res = 9'd0;
    end else if (idx <= 7'h20) begin
      res = {1'b1, 1'b0, idx};
    end else if (idx == 7'h21) begin
      res = {1'b1, DelByte};
    end else if (idx <= 7'h42) begin
      res = {1'b1, 8'({1'b0, idx} + 8'h5E)};
    end else begin
      res = {1'b1, ShyByte};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/byte_level_bpe_token_decoder_unit.sv =====
`default_nettype none
// The first result of a byte is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while each byte gives at most one result and out_ready_i
// is held high; a byte that gives several results emits them one after another through
// the output register, with a two-entry queue between the classifier and the output register absorbing the difference.
// Reset: byte-level mode, no held bytes, queue and output register empty.
module byte_level_bpe_token_decoder_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_metaspace_mode_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       token_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            token_done_o
);
  import bbd_pkg::*;

  logic push;
  logic full;
  logic head_valid;
  logic pop;
  cmd_t cmd;
  cmd_t head;

  assign cfg_ready_o = 1'b1;

  bbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_mode_i  (cfg_metaspace_mode_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .token_end_i (token_end_i),
    .push_o      (push),
    .cmd_o       (cmd),
    .full_i      (full)
  );

  bbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  bbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .token_done_o (token_done_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/bbd_front.sv =====
`default_nettype none
module bbd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic          cfg_mode_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          token_end_i,
  output logic               push_o,
  output bbd_pkg::cmd_t      cmd_o,
  input  wire logic          full_i
);
  import bbd_pkg::*;

  logic       mode_q;
  logic [1:0] held_count_q, held_count_d;
  logic [7:0] held_lead_q, held_lead_d;
  logic [1:0] n;
  logic       pass;
  logic [8:0] mapped;
  logic       accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // Classify the byte against the held state and collect results
  always_comb begin
    n            = 2'd0;
    pass         = 1'b1;
    cmd_o        = '0;
    cmd_o.data_vld = 1'b1;
    held_count_d = held_count_q;
    held_lead_d  = held_lead_q;
    mapped       = cp_map({held_lead_q[4:0], in_byte_i[5:0]});
    if (mode_q) begin
      if (held_count_q == HeldTwo) begin
        held_count_d = HeldNone;
        if (in_byte_i == MsLast) begin
          cmd_o.data[0] = SpaceByte;
          n             = 2'd1;
          pass          = 1'b0;
        end else begin
          cmd_o.data[0] = MsLead;
          cmd_o.data[1] = MsMid;
          n             = 2'd2;
        end
      end else if (held_count_q == HeldOne) begin
        if (in_byte_i == MsMid) begin
          held_count_d = HeldTwo;
          pass         = 1'b0;
        end else begin
          held_count_d  = HeldNone;
          cmd_o.data[0] = MsLead;
          n             = 2'd1;
        end
      end
      if (pass) begin
        if (in_byte_i == MsLead) begin
          held_count_d = HeldOne;
        end else begin
          cmd_o.data[n] = in_byte_i;
          n             = n + 2'd1;
        end
      end
    end else begin
      if (held_count_q != HeldNone) begin
        held_count_d = HeldNone;
        if ((in_byte_i & ContMask) == ContCode) begin
          pass = 1'b0;
          if (mapped[8]) begin
            cmd_o.data[0] = mapped[7:0];
            n             = 2'd1;
          end
        end else begin
          cmd_o.data[0] = held_lead_q;
          n             = 2'd1;
        end
      end
      if (pass) begin
        if ((in_byte_i & LeadMask) == LeadCode) begin
          held_count_d = HeldOne;
          held_lead_d  = in_byte_i;
        end else begin
          cmd_o.data[n] = in_byte_i;
          n             = n + 2'd1;
        end
      end
    end
    // Flush held bytes at token end
    if (token_end_i) begin
      if (mode_q) begin
        if (held_count_d != HeldNone) begin
          cmd_o.data[n] = MsLead;
          n             = n + 2'd1;
        end
        if (held_count_d == HeldTwo) begin
          cmd_o.data[n] = MsMid;
          n             = n + 2'd1;
        end
      end else if (held_count_d != HeldNone) begin
        cmd_o.data[n] = held_lead_d;
        n             = n + 2'd1;
      end
      held_count_d = HeldNone;
      held_lead_d  = '0;
      if (n == 2'd0) begin
        n              = 2'd1;
        cmd_o.data_vld = 1'b0;
      end
    end
    cmd_o.cnt  = n;
    cmd_o.done = token_end_i;
  end

  // Hold mode and held bytes; a register write drops held bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      held_count_q <= HeldNone;
      held_lead_q  <= '0;
    end else if (cfg_valid_i) begin
      mode_q       <= cfg_mode_i;
      held_count_q <= HeldNone;
      held_lead_q  <= '0;
    end else if (accept) begin
      held_count_q <= held_count_d;
      held_lead_q  <= held_lead_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bbd_queue.sv =====
`default_nettype none
module bbd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bbd_pkg::cmd_t cmd_i,
  output logic               full_o,
  output logic               head_valid_o,
  output bbd_pkg::cmd_t      head_o,
  input  wire logic          pop_i
);
  import bbd_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Store entries; only non-empty commands are stored
  always_ff @(posedge clk_i) begin
    if (do_push && (cmd_i.cnt != 2'd0)) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push && (cmd_i.cnt != 2'd0)) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push && (cmd_i.cnt != 2'd0)} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bbd_back.sv =====
`default_nettype none
module bbd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire bbd_pkg::cmd_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic               token_done_o
);
  import bbd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       bvld_q;
  logic       done_q;
  logic       load;
  logic       last_slot;

  assign load      = head_valid_i && (!valid_q || out_ready_i);
  assign last_slot = (idx_q == (head_i.cnt - 2'd1));
  assign pop_o     = load && last_slot;

  // Step through the slots of the head command
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = last_slot ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.data[idx_q];
      bvld_q <= head_i.data_vld;
      done_q <= head_i.done && last_slot;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bvld_q;
  assign token_done_o = done_q;

endmodule
`default_nettype wire
